// ===== hw/rtl/weighted_knn_mean_max_accum_unit_macros.svh =====
// Assertion macros for the weighted kNN mean/max unit.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef WEIGHTED_KNN_MEAN_MAX_ACCUM_UNIT_MACROS_SVH
`define WEIGHTED_KNN_MEAN_MAX_ACCUM_UNIT_MACROS_SVH

// same-cycle implication
`define WKM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wkm_pkg.sv =====
// Shared types, constants and the exp(-i/16) weight table for the weighted kNN unit.
// No dependencies.
package wkm_pkg;

  localparam int COORD_W        = 16;
  localparam int INDEX_W        = 16;
  localparam int COUNT_W        = 7;
  localparam int INV_W          = 17;
  localparam int EXP_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;
  localparam int RESULT_W       = 24;
  localparam int MAX_NEIGHBORS  = 64;
  localparam int WEIGHT_W       = 17;
  localparam int WEIGHT_TABLE_DEPTH = 256;
  localparam int LUT_IDX_W      = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int SUM_W          = RESULT_W + $clog2(MAX_NEIGHBORS);
  localparam int MAX_W          = 27;
  localparam int DSQ_W          = 2 * COORD_W;
  localparam int KD_W           = DSQ_W + EXP_W;
  localparam int PROD_W         = SUM_W + INV_W + 1;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EXPONENT = 2'd2;

  localparam logic [COUNT_W-1:0] NEIGHBOR_COUNT_RST  = 7'd16;
  localparam logic [INV_W-1:0]   INVERSE_COUNT_RST   = 17'd4096;
  localparam logic [EXP_W-1:0]   WEIGHT_EXPONENT_RST = 16'd4096;

  // -1000 in Q11.16, below any weighted feature
  localparam logic signed [MAX_W-1:0] MAX_START = MAX_W'(-1000 * 65536);

  localparam logic [63:0] DECAY_STEP_Q31 = 64'd2017374193;

  typedef logic [WEIGHT_W-1:0] weight_lut_t [WEIGHT_TABLE_DEPTH];

  // Q1.31 recurrence for exp(-i/16), rounded to Q1.16
  function automatic weight_lut_t build_weight_lut();
    weight_lut_t lut;
    logic [63:0] e;
    logic [63:0] r;
    e = 64'd1 << 31;
    for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++) begin
      if (i > 0) begin
        e = (e * DECAY_STEP_Q31 + (64'd1 << 30)) >> 31;
      end
      r = (e + (64'd1 << 14)) >> 15;
      lut[i] = r[WEIGHT_W-1:0];
    end
    return lut;
  endfunction

  localparam weight_lut_t WEIGHT_LUT = build_weight_lut();

  typedef struct packed {
    logic load_in;
    logic sq;
    logic kd;
    logic wt;
    logic wf;
    logic acc;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

// ===== hw/rtl/wkm_ctrl.sv =====
// Sequencer for the weighted kNN unit: steps one item through the datapath.
// Depends on wkm_pkg and the assertion macro header.
`include "weighted_knn_mean_max_accum_unit_macros.svh"

module wkm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  wkm_pkg::status_t status,
  output wkm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_KD,
    S_WT,
    S_WF,
    S_ACC,
    S_MUL,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SQ;
      S_SQ:    state_next = S_KD;
      S_KD:    state_next = S_WT;
      S_WT:    state_next = S_WF;
      S_WF:    state_next = S_ACC;
      S_ACC:   state_next = status.last ? S_MUL : S_IDLE;
      S_MUL:   state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == S_IDLE) && in_valid && !in_stall;
    cmd.sq       = (state == S_SQ);
    cmd.kd       = (state == S_KD);
    cmd.wt       = (state == S_WT);
    cmd.wf       = (state == S_WF);
    cmd.acc      = (state == S_ACC);
    cmd.mul      = (state == S_MUL);
    cmd.load_out = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `WKM_ASSERT_NOW(a_stall_tracks_state, 1'b1, in_stall == (state != S_IDLE), "stall out of step")
  `WKM_ASSERT_NEXT(a_result_waits, (state == S_FIN) && out_valid && out_stall, state == S_FIN, "result overwritten")
  `WKM_ASSERT_NEXT(a_group_continues, (state == S_ACC) && !status.last, !in_stall, "input not reopened")

endmodule

// ===== hw/rtl/wkm_dpath.sv =====
// Datapath for the weighted kNN unit: config registers, weight, accumulators, mean.
// Depends on wkm_pkg and the assertion macro header.
`include "weighted_knn_mean_max_accum_unit_macros.svh"

module wkm_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wkm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wkm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [wkm_pkg::COORD_W-1:0]   center_coord,
  input  logic signed [wkm_pkg::COORD_W-1:0]   neighbor_coord,
  input  logic signed [wkm_pkg::COORD_W-1:0]   neighbor_feature,
  input  logic [wkm_pkg::INDEX_W-1:0]          neighbor_index,
  input  wkm_pkg::cmd_t                        cmd,
  output wkm_pkg::status_t                     status,
  output logic signed [wkm_pkg::RESULT_W-1:0]  mean_value,
  output logic signed [wkm_pkg::RESULT_W-1:0]  max_value,
  output logic [wkm_pkg::INDEX_W-1:0]          max_index
);

  // configuration
  logic [wkm_pkg::COUNT_W-1:0] neighbor_count;
  logic [wkm_pkg::INV_W-1:0]   inverse_count;
  logic [wkm_pkg::EXP_W-1:0]   weight_exponent;

  // item registers
  logic signed [wkm_pkg::COORD_W-1:0] center_q;
  logic signed [wkm_pkg::COORD_W-1:0] neighbor_q;
  logic signed [wkm_pkg::COORD_W-1:0] feature_q;
  logic [wkm_pkg::INDEX_W-1:0]        index_q;
  logic [wkm_pkg::DSQ_W-1:0]          dsq;
  logic [wkm_pkg::KD_W-1:0]           kd;
  logic [wkm_pkg::WEIGHT_W-1:0]       weight;
  logic signed [wkm_pkg::RESULT_W-1:0] wfeat;
  logic signed [wkm_pkg::PROD_W-1:0]  prod;

  // group state
  logic signed [wkm_pkg::SUM_W-1:0]   running_sum;
  logic signed [wkm_pkg::MAX_W-1:0]   running_max;
  logic [wkm_pkg::INDEX_W-1:0]        best_index;
  logic [wkm_pkg::COUNT_W-1:0]        items_seen;

  logic signed [wkm_pkg::COORD_W:0]   diff;
  logic [wkm_pkg::COORD_W-1:0]        abs_diff;
  logic [wkm_pkg::LUT_IDX_W-1:0]      lut_idx;
  logic signed [wkm_pkg::WEIGHT_W+wkm_pkg::COORD_W:0] wprod;
  logic [wkm_pkg::COUNT_W-1:0]        count_eff;
  logic [wkm_pkg::COUNT_W-1:0]        items_inc;
  logic signed [wkm_pkg::PROD_W-17:0] mean_wide;
  logic signed [wkm_pkg::RESULT_W-1:0] mean_sat;

  assign diff     = {center_q[wkm_pkg::COORD_W-1], center_q}
                  - {neighbor_q[wkm_pkg::COORD_W-1], neighbor_q};
  assign abs_diff = diff[wkm_pkg::COORD_W] ? wkm_pkg::COORD_W'(-diff)
                                           : diff[wkm_pkg::COORD_W-1:0];

  // Q4.4 index taken from the Q.28 product, saturated at the table end
  assign lut_idx = (kd[wkm_pkg::KD_W-1:24] > (wkm_pkg::KD_W-24)'(wkm_pkg::WEIGHT_TABLE_DEPTH-1))
                 ? wkm_pkg::LUT_IDX_W'(wkm_pkg::WEIGHT_TABLE_DEPTH-1)
                 : kd[24 +: wkm_pkg::LUT_IDX_W];

  assign wprod = feature_q * $signed({1'b0, weight});

  assign count_eff = (neighbor_count == '0) ? wkm_pkg::COUNT_W'(1)
                   : (neighbor_count > wkm_pkg::COUNT_W'(wkm_pkg::MAX_NEIGHBORS))
                     ? wkm_pkg::COUNT_W'(wkm_pkg::MAX_NEIGHBORS) : neighbor_count;
  assign items_inc   = items_seen + wkm_pkg::COUNT_W'(1);
  assign status.last = (items_inc >= count_eff);

  // floor(prod / 2^16), clipped to Q8.16
  assign mean_wide = prod[wkm_pkg::PROD_W-1:16];
  always_comb begin
    if (mean_wide > (wkm_pkg::PROD_W-16)'(8388607)) begin
      mean_sat = wkm_pkg::RESULT_W'(8388607);
    end else if (mean_wide < -(wkm_pkg::PROD_W-16)'(8388608)) begin
      mean_sat = wkm_pkg::RESULT_W'(-8388608);
    end else begin
      mean_sat = mean_wide[wkm_pkg::RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count  <= wkm_pkg::NEIGHBOR_COUNT_RST;
      inverse_count   <= wkm_pkg::INVERSE_COUNT_RST;
      weight_exponent <= wkm_pkg::WEIGHT_EXPONENT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wkm_pkg::REG_NEIGHBOR_COUNT:  neighbor_count  <= cfg_data[wkm_pkg::COUNT_W-1:0];
        wkm_pkg::REG_INVERSE_COUNT:   inverse_count   <= cfg_data[wkm_pkg::INV_W-1:0];
        wkm_pkg::REG_WEIGHT_EXPONENT: weight_exponent <= cfg_data[wkm_pkg::EXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      center_q   <= center_coord;
      neighbor_q <= neighbor_coord;
      feature_q  <= neighbor_feature;
      index_q    <= neighbor_index;
    end
    if (cmd.sq) begin
      dsq <= abs_diff * abs_diff;
    end
    if (cmd.kd) begin
      kd <= dsq * weight_exponent;
    end
    if (cmd.wt) begin
      weight <= wkm_pkg::WEIGHT_LUT[lut_idx];
    end
    if (cmd.wf) begin
      // result always fits 24 bits, so the arithmetic shift is a part-select
      wfeat <= wprod[8 +: wkm_pkg::RESULT_W];
    end
    if (cmd.mul) begin
      prod <= running_sum * $signed({1'b0, inverse_count});
    end
    if (cmd.load_out) begin
      mean_value <= mean_sat;
      max_value  <= running_max[wkm_pkg::RESULT_W-1:0];
      max_index  <= best_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      running_sum <= '0;
      running_max <= wkm_pkg::MAX_START;
      best_index  <= '0;
      items_seen  <= '0;
    end else if (cmd.acc) begin
      running_sum <= running_sum + wkm_pkg::SUM_W'(wfeat);
      if (wkm_pkg::MAX_W'(wfeat) > running_max) begin
        running_max <= wkm_pkg::MAX_W'(wfeat);
        best_index  <= index_q;
      end
      items_seen <= items_inc;
    end
  end

  `WKM_ASSERT_NOW(a_count_bound, 1'b1, items_seen <= wkm_pkg::COUNT_W'(wkm_pkg::MAX_NEIGHBORS), "group overran")
  `WKM_ASSERT_NEXT(a_group_cleared, cmd.load_out, (running_sum == '0) && (items_seen == '0), "group not cleared")
  `WKM_ASSERT_NEXT(a_max_monotone, cmd.acc, running_max >= $past(running_max), "max decreased")

endmodule

// ===== hw/rtl/weighted_knn_mean_max_accum_unit.sv =====
// Gaussian-weighted kNN mean/max accumulator: one neighbour item at a time.
// in_stall stays high until the previous item has finished, so one item is in flight at a time.
// Result: out_valid rises after the closing item's 5-step sequence (square, scale, weight lookup,
// weight multiply, accumulate) and one mean multiply; a held result stalls only the next close.
// Reset (rst, synchronous): registers to defaults, group state cleared, no result pending.
// Depends on wkm_pkg, wkm_ctrl and wkm_dpath.
module weighted_knn_mean_max_accum_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wkm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wkm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wkm_pkg::COORD_W-1:0]   center_coord,
  input  logic signed [wkm_pkg::COORD_W-1:0]   neighbor_coord,
  input  logic signed [wkm_pkg::COORD_W-1:0]   neighbor_feature,
  input  logic [wkm_pkg::INDEX_W-1:0]          neighbor_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wkm_pkg::RESULT_W-1:0]  mean_value,
  output logic signed [wkm_pkg::RESULT_W-1:0]  max_value,
  output logic [wkm_pkg::INDEX_W-1:0]          max_index
);

  wkm_pkg::cmd_t    cmd;
  wkm_pkg::status_t status;

  wkm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wkm_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .center_coord     (center_coord),
    .neighbor_coord   (neighbor_coord),
    .neighbor_feature (neighbor_feature),
    .neighbor_index   (neighbor_index),
    .cmd              (cmd),
    .status           (status),
    .mean_value       (mean_value),
    .max_value        (max_value),
    .max_index        (max_index)
  );

endmodule
